/* hdl/uniform_grid_trilinear_interp_unit_macros.svh */
// Assertion macros for the interpolation unit top level.
`ifndef UNIFORM_GRID_TRILINEAR_INTERP_UNIT_MACROS_SVH
`define UNIFORM_GRID_TRILINEAR_INTERP_UNIT_MACROS_SVH
`ifndef SYNTH
`define UGTI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define UGTI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define UGTI_ASSERT(lbl, clk, rstn, prop, msg)
`define UGTI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hdl/ugti_pkg.sv */
// Types and constants shared by the interpolation unit.
package ugti_pkg;
  localparam int DataW      = 32;
  localparam int AddrW      = 12;
  localparam int TableDepth = 4096;
  localparam int FracW      = 17;
  localparam int FracShift  = 16;
  localparam int DiffW      = 33;
  localparam int PosW       = 48;
  localparam int CfgIdxW    = 3;
  localparam int NumStages  = 11;

  localparam logic [DataW-1:0] ScaleOne = 32'h0001_0000;
  localparam logic [FracW-1:0] FracOne  = 17'h1_0000;

  typedef logic [AddrW-1:0]        addr_t;
  typedef logic [FracW-1:0]        frac_t;
  typedef logic signed [DataW-1:0] data_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreeAxes,
    CfgXLow,
    CfgXScale,
    CfgYLow,
    CfgYScale,
    CfgZLow,
    CfgZScale
  } cfg_idx_e;

  typedef enum logic {
    ReqWrite  = 1'b0,
    ReqLookup = 1'b1
  } req_type_e;

  typedef struct packed {
    logic  lookup;
    addr_t idx;
    data_t value;
  } front_t;

  typedef struct packed {
    logic  lookup;
    logic  oor;
    frac_t fx;
    frac_t fy;
    frac_t fz;
  } side_t;
endpackage

/* hdl/ugti_if.sv */
// Channel interfaces: request, response and configuration write.
interface ugti_req_if import ugti_pkg::*;;
  logic  valid;
  logic  ready;
  logic  req_type;
  addr_t entry_index;
  data_t entry_value;
  data_t x_coord;
  data_t y_coord;
  data_t z_coord;

  modport source (output valid, req_type, entry_index, entry_value, x_coord, y_coord,
                  z_coord, input ready);
  modport sink (input valid, req_type, entry_index, entry_value, x_coord, y_coord,
                z_coord, output ready);
endinterface

interface ugti_rsp_if import ugti_pkg::*;;
  logic  valid;
  logic  ready;
  data_t interp_value;
  logic  out_of_range;

  modport source (output valid, interp_value, out_of_range, input ready);
  modport sink (input valid, interp_value, out_of_range, output ready);
endinterface

interface ugti_cfg_if import ugti_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/ugti_axis.sv */
// Per-axis grid position: offset, scale multiply, clamp and cell split.
module ugti_axis import ugti_pkg::*; #(
  parameter int POINTS = 16,
  localparam int CW = $clog2(POINTS)
) (
  input  logic          clk_i,
  input  logic [2:0]    en_i,
  input  data_t         coord_i,
  input  data_t         low_i,
  input  logic [31:0]   scale_i,
  output logic [CW-1:0] cell_o,
  output frac_t         frac_o,
  output logic          oor_o
);
  localparam logic [PosW-1:0] Top     = PosW'(POINTS - 1) << FracShift;
  localparam logic [31:0]     CellMax = 32'(POINTS - 2);

  logic signed [DiffW-1:0] diff_q;
  logic                    neg_q;
  logic [PosW-1:0]         pos_q;
  logic [63:0]             prod;
  logic [PosW-1:0]         pos_c;
  logic [PosW-1:0]         base;
  logic [31:0]             cell_raw;
  logic [CW-1:0]           cell_d;
  logic                    oor_d;

  assign prod = diff_q[31:0] * scale_i;

  always_comb begin
    oor_d = 1'b0;
    if (neg_q) begin
      pos_c = '0;
      oor_d = 1'b1;
    end else if (pos_q > Top) begin
      pos_c = Top;
      oor_d = 1'b1;
    end else begin
      pos_c = pos_q;
    end
    cell_raw = pos_c[PosW-1:FracShift];
    if (cell_raw > CellMax) begin
      cell_d = CW'(POINTS - 2);
    end else begin
      cell_d = cell_raw[CW-1:0];
    end
    base = PosW'(cell_d) << FracShift;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      diff_q <= {coord_i[DataW-1], coord_i} - {low_i[DataW-1], low_i};
    end
    if (en_i[1]) begin
      neg_q <= diff_q[DiffW-1];
      pos_q <= prod[63:FracShift];
    end
    if (en_i[2]) begin
      cell_o <= cell_d;
      frac_o <= FracW'(pos_c - base);
      oor_o  <= oor_d;
    end
  end
endmodule

/* hdl/ugti_ram.sv */
// One copy of the sample table with a registered read port.
module ugti_ram import ugti_pkg::*; (
  input  logic  clk_i,
  input  logic  we_i,
  input  addr_t waddr_i,
  input  data_t wdata_i,
  input  logic  re_i,
  input  addr_t raddr_i,
  output data_t rdata_o
);
  data_t mem_q [TableDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

/* hdl/ugti_blend.sv */
// Linear blend a + ((b - a) * f) >> 16 in a multiply stage and an add stage.
module ugti_blend import ugti_pkg::*; (
  input  logic  clk_i,
  input  logic  en_mul_i,
  input  logic  en_add_i,
  input  data_t a_i,
  input  data_t b_i,
  input  frac_t f_i,
  output data_t y_o
);
  logic signed [DataW:0]       delta;
  logic signed [FracW:0]       fs;
  logic signed [DataW+FracW:0] prod_q;
  logic signed [DataW+FracW:0] shifted;
  data_t                       a_q;

  assign delta   = {b_i[DataW-1], b_i} - {a_i[DataW-1], a_i};
  assign fs      = {1'b0, f_i};
  assign shifted = prod_q >>> FracShift;

  always_ff @(posedge clk_i) begin
    if (en_mul_i) begin
      prod_q <= delta * fs;
      a_q    <= a_i;
    end
    if (en_add_i) begin
      y_o <= a_q + shifted[DataW-1:0];
    end
  end
endmodule

/* hdl/uniform_grid_trilinear_interp_unit.sv */
// Top level of the uniform-grid bilinear and trilinear interpolation unit.
//
// Requests arrive on req_i. A write beat stores entry_value at entry_index and
// returns nothing. A lookup beat returns one beat on rsp_o with the blended
// Q16.16 value and an out-of-range flag.
// Configuration registers are written on cfg_i, which is always ready; writes
// belong to times when no request is in flight.
// The datapath is an eleven-stage pipeline: offset, scale multiply, clamp,
// corner addresses, table read, then a multiply and an add stage for each of
// the z, y and x blends. One beat can be accepted every cycle unless a stall
// on rsp_o has filled the pipeline.
// The eight corner samples come from eight copies of the table, each with one
// read port; every write goes to all copies.
// Reset clears the valid bits and loads the register defaults. The table
// contents are not cleared.
// When rsp_o stalls, stages without a valid beat still fill, so req_i stays
// ready until the pipeline is full.
`include "uniform_grid_trilinear_interp_unit_macros.svh"

module uniform_grid_trilinear_interp_unit import ugti_pkg::*; #(
  parameter int X_POINTS = 16,
  parameter int Y_POINTS = 16,
  parameter int Z_POINTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ugti_cfg_if.sink   cfg_i,
  ugti_req_if.sink   req_i,
  ugti_rsp_if.source rsp_o
);
  localparam int XW = $clog2(X_POINTS);
  localparam int YW = $clog2(Y_POINTS);
  localparam int ZW = $clog2(Z_POINTS);
  localparam int L  = NumStages - 1;

  logic        three_q;
  data_t       x_low_q, y_low_q, z_low_q;
  logic [31:0] x_scale_q, y_scale_q, z_scale_q;

  logic [NumStages-1:0] v_q, v_d, en;
  front_t               front_q [4];
  side_t                side_q [3:L];

  logic [XW-1:0] cell_x;
  logic [YW-1:0] cell_y;
  logic [ZW-1:0] cell_z;
  frac_t         fx, fy, fz;
  logic          oor_x, oor_y, oor_z;

  addr_t ia, ja, ka, yp, zp, r0, r1;
  addr_t base [4];
  addr_t lo_d [4];
  addr_t hi_d [4];
  addr_t lo_q [4];
  addr_t hi_q [4];
  data_t smp_lo [4];
  data_t smp_hi [4];
  data_t cz [4];
  data_t cy [2];
  logic  mem_we;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_q   <= 1'b1;
      x_low_q   <= '0;
      y_low_q   <= '0;
      z_low_q   <= '0;
      x_scale_q <= ScaleOne;
      y_scale_q <= ScaleOne;
      z_scale_q <= ScaleOne;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgThreeAxes: three_q   <= cfg_i.data[0];
        CfgXLow:      x_low_q   <= cfg_i.data;
        CfgXScale:    x_scale_q <= cfg_i.data;
        CfgYLow:      y_low_q   <= cfg_i.data;
        CfgYScale:    y_scale_q <= cfg_i.data;
        CfgZLow:      z_low_q   <= cfg_i.data;
        CfgZScale:    z_scale_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    en[L] = !v_q[L] || !side_q[L].lookup || rsp_o.ready;
    for (int k = L - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = {v_q[L-1:0], req_i.valid};
  end

  assign req_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      front_q[0] <= '{lookup: (req_i.req_type == ReqLookup), idx: req_i.entry_index,
                      value: req_i.entry_value};
    end
    for (int k = 1; k < 4; k++) begin
      if (en[k]) begin
        front_q[k] <= front_q[k-1];
      end
    end
    if (en[3]) begin
      side_q[3] <= '{lookup: front_q[2].lookup,
                     oor: oor_x || oor_y || (three_q && oor_z),
                     fx: fx, fy: fy, fz: three_q ? fz : '0};
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    for (int k = 4; k < NumStages; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  ugti_axis #(.POINTS(X_POINTS)) u_axis_x (
    .clk_i, .en_i(en[2:0]), .coord_i(req_i.x_coord), .low_i(x_low_q),
    .scale_i(x_scale_q), .cell_o(cell_x), .frac_o(fx), .oor_o(oor_x)
  );
  ugti_axis #(.POINTS(Y_POINTS)) u_axis_y (
    .clk_i, .en_i(en[2:0]), .coord_i(req_i.y_coord), .low_i(y_low_q),
    .scale_i(y_scale_q), .cell_o(cell_y), .frac_o(fy), .oor_o(oor_y)
  );
  ugti_axis #(.POINTS(Z_POINTS)) u_axis_z (
    .clk_i, .en_i(en[2:0]), .coord_i(req_i.z_coord), .low_i(z_low_q),
    .scale_i(z_scale_q), .cell_o(cell_z), .frac_o(fz), .oor_o(oor_z)
  );

  always_comb begin
    ia = AddrW'(cell_x);
    ja = AddrW'(cell_y);
    ka = AddrW'(cell_z);
    yp = AddrW'(Y_POINTS);
    zp = AddrW'(Z_POINTS);
    r0 = ia * yp + ja;
    r1 = (ia + 1'b1) * yp + ja;
    base[0] = r0;
    base[1] = r0 + 1'b1;
    base[2] = r1;
    base[3] = r1 + 1'b1;
    for (int c = 0; c < 4; c++) begin
      if (three_q) begin
        lo_d[c] = base[c] * zp + ka;
        hi_d[c] = lo_d[c] + 1'b1;
      end else begin
        lo_d[c] = base[c];
        hi_d[c] = base[c];
      end
    end
  end

  assign mem_we = en[4] && v_q[3] && !front_q[3].lookup;

  for (genvar c = 0; c < 4; c++) begin : g_corner
    ugti_ram u_ram_lo (
      .clk_i, .we_i(mem_we), .waddr_i(front_q[3].idx), .wdata_i(front_q[3].value),
      .re_i(en[4]), .raddr_i(lo_q[c]), .rdata_o(smp_lo[c])
    );
    ugti_ram u_ram_hi (
      .clk_i, .we_i(mem_we), .waddr_i(front_q[3].idx), .wdata_i(front_q[3].value),
      .re_i(en[4]), .raddr_i(hi_q[c]), .rdata_o(smp_hi[c])
    );
    ugti_blend u_blend_z (
      .clk_i, .en_mul_i(en[5]), .en_add_i(en[6]), .a_i(smp_lo[c]), .b_i(smp_hi[c]),
      .f_i(side_q[4].fz), .y_o(cz[c])
    );
  end

  for (genvar r = 0; r < 2; r++) begin : g_row
    ugti_blend u_blend_y (
      .clk_i, .en_mul_i(en[7]), .en_add_i(en[8]), .a_i(cz[2*r]), .b_i(cz[2*r+1]),
      .f_i(side_q[6].fy), .y_o(cy[r])
    );
  end

  ugti_blend u_blend_x (
    .clk_i, .en_mul_i(en[9]), .en_add_i(en[10]), .a_i(cy[0]), .b_i(cy[1]),
    .f_i(side_q[8].fx), .y_o(rsp_o.interp_value)
  );

  assign rsp_o.valid        = v_q[L] && side_q[L].lookup;
  assign rsp_o.out_of_range = side_q[L].oor;

  `UGTI_ASSERT(a_block_only_when_full, clk_i, rst_ni, !req_i.ready |-> (&v_q), "request blocked with a free stage")
  `UGTI_ASSERT(a_frac_bound, clk_i, rst_ni, (v_q[3] && side_q[3].lookup) |-> (side_q[3].fx <= FracOne && side_q[3].fy <= FracOne && side_q[3].fz <= FracOne), "fraction above one")
  `UGTI_ASSERT(a_planar_no_z, clk_i, rst_ni, (v_q[3] && side_q[3].lookup && !three_q) |-> (side_q[3].fz == '0), "z fraction used in planar mode")
  `UGTI_ASSERT_NEXT(a_stall_freezes, clk_i, rst_ni, rsp_o.valid && !rsp_o.ready && (&v_q), $stable(v_q), "full pipeline moved under stall")
endmodule
